### rtl/wwts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwts_pkg: shared types for the weighted window token sum
// Token and sum widths, and the step controls passed from control to datapath.
// ----------------------------------------------------------------------------
package wwts_pkg;

  localparam int TOKEN_W = 8;
  localparam int SUM_W   = 17;

  typedef logic [TOKEN_W-1:0] token_t;
  typedef logic [SUM_W-1:0]   sum_t;

  // one advance of the cell chain
  typedef struct packed {
    logic step;       // chain advances this cycle
    logic feed_zero;  // padding token during flush
    logic emit;       // the result formed by this step is a real one
    logic last;       // final result of the string
  } step_ctrl_t;

endpackage
`default_nettype wire

### rtl/wwts_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwts_cell: one tap of the transposed weighted sum
// Adds its weighted token to the partial sum from its upstream neighbor.
// ----------------------------------------------------------------------------
module wwts_cell #(
  parameter int COEF = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire wwts_pkg::token_t x,
  input  wire wwts_pkg::sum_t   sum_in,
  output wwts_pkg::sum_t        sum_out
);

  localparam wwts_pkg::sum_t COEF_S = wwts_pkg::sum_t'(COEF);

  wwts_pkg::sum_t acc;
  wwts_pkg::sum_t acc_next;

  // sums wrap modulo the result width
  always_comb begin
    acc_next = wwts_pkg::sum_t'(wwts_pkg::sum_t'(x) * COEF_S) + sum_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (step) begin
      acc <= acc_next;
    end
  end

  assign sum_out = acc;

endmodule
`default_nettype wire

### rtl/wwts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wwts_ctrl: fill tracking and end-of-string flush sequencing
// Decides when the chain advances and whether that advance yields a result.
// ----------------------------------------------------------------------------
module wwts_ctrl #(
  parameter int WINDOW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          token_valid,
  input  wire logic          end_of_string,
  input  wire logic          sum_valid,
  input  wire logic          sum_ready,
  output logic               token_ready,
  output wwts_pkg::step_ctrl_t ctrl
);

  localparam int CNT_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW - 1);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] flush_left;
  logic             flushing;
  logic             out_free;

  assign out_free    = !sum_valid || sum_ready;
  assign token_ready = !flushing && out_free;

  always_comb begin
    ctrl.step      = flushing ? out_free : (token_valid && out_free);
    ctrl.feed_zero = flushing;
    ctrl.emit      = (fill == FULL);
    ctrl.last      = flushing && (flush_left == CNT_W'(1));
    fill_next      = (fill == FULL) ? fill : fill + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      flush_left <= '0;
      flushing   <= 1'b0;
    end else if (ctrl.step) begin
      if (flushing) begin
        if (flush_left == CNT_W'(1)) begin
          flushing <= 1'b0;
          fill     <= '0;
        end else begin
          flush_left <= flush_left - CNT_W'(1);
          fill       <= fill_next;
        end
      end else begin
        fill <= fill_next;
        if (end_of_string) begin
          // pad with zeros until every position of the string is out
          flushing   <= 1'b1;
          flush_left <= FULL;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/weighted_window_token_sum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_window_token_sum: sliding weighted fingerprint over a token stream
// Row of WINDOW cells in transposed form with fixed odd weights.
// ----------------------------------------------------------------------------
// Usage:
//   token channel (token, end_of_string) and sum channel (window_sum,
//   last_sum) both use valid/ready; a transfer happens when both are high.
//   While streaming, one token is taken every cycle. Once WINDOW tokens of a
//   string have arrived, each token transfer yields one sum, available in the
//   cycle after the token transfer.
//   A token marked end_of_string starts a flush in which zeros are fed down
//   the chain; token_ready is low during the flush. The flush yields the
//   remaining sums (truncated windows), oldest position first, the last one
//   marked with last_sum, and clears every cell but cell 0, which holds it.
//   The sum output is a register; when the receiver stalls, the chain holds
//   and token_ready drops until the waiting sum is taken.
//   Reset clears all cells, the fill count and the output valid.
// ----------------------------------------------------------------------------
module weighted_window_token_sum #(
  parameter int WINDOW = 20
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            token_valid,
  output logic                 token_ready,
  input  wire wwts_pkg::token_t token,
  input  wire logic            end_of_string,
  output logic                 sum_valid,
  input  wire logic            sum_ready,
  output wwts_pkg::sum_t       window_sum,
  output logic                 last_sum
);

  wwts_pkg::step_ctrl_t ctrl;
  wwts_pkg::token_t     x;
  wwts_pkg::sum_t       chain [0:WINDOW];

  wwts_ctrl #(
    .WINDOW(WINDOW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .token_valid  (token_valid),
    .end_of_string(end_of_string),
    .sum_valid    (sum_valid),
    .sum_ready    (sum_ready),
    .token_ready  (token_ready),
    .ctrl         (ctrl)
  );

  assign x             = ctrl.feed_zero ? '0 : token;
  assign chain[WINDOW] = '0;

  // cell 0 carries weight 2*(WINDOW-1)+1 for the newest token and doubles as
  // the output register
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    wwts_cell #(
      .COEF(2 * (WINDOW - 1 - k) + 1)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .step   (ctrl.step),
      .x      (x),
      .sum_in (chain[k+1]),
      .sum_out(chain[k])
    );
  end

  assign window_sum = chain[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      last_sum  <= 1'b0;
    end else if (ctrl.step) begin
      sum_valid <= ctrl.emit;
      last_sum  <= ctrl.last;
    end else if (sum_ready) begin
      sum_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
